### hw/rtl/vurp_pkg.sv
package vurp_pkg;

  localparam int VRAM_DEPTH = 12288;
  localparam int VRAM_AW    = 14;
  localparam int SPR_DEPTH  = 256;
  localparam int PAL_DEPTH  = 32;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  localparam logic [2:0] REG_CONTROL  = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  localparam logic [2:0] CFG_PAGE_A  = 3'd0;
  localparam logic [2:0] CFG_PAGE_B  = 3'd1;
  localparam logic [2:0] CFG_PAGE_C  = 3'd2;
  localparam logic [2:0] CFG_PAGE_D  = 3'd3;
  localparam logic [2:0] CFG_PAT_WR  = 3'd4;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic       set_vblank;
    logic       set_sprite_hit;
    logic       set_overflow;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [13:0] current_address;
    logic [13:0] pending_address;
    logic [2:0]  fine_x;
    logic [2:0]  fine_y;
    logic [7:0]  control_value;
    logic [7:0]  mask_value;
    logic        write_toggle;
  } out_item_t;

endpackage

### hw/rtl/video_unit_register_port.sv
// A result is registered and presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle outside the clearing pass; the single output
// register lets a new transaction in whenever the previous result is taken in the same cycle.
// Reset is synchronous and active low. After reset the video and sprite memories
// are cleared one entry per cycle across all 12288 video entries, with in_stall held high.
module video_unit_register_port (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vurp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vurp_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [1:0]           cfg_data
);

  logic [7:0] vram_mem [vurp_pkg::VRAM_DEPTH];
  logic [7:0] spr_mem  [vurp_pkg::SPR_DEPTH];
  logic [7:0] pal_r    [vurp_pkg::PAL_DEPTH];

  logic [1:0]  nt_page_r [4];
  logic        pat_wr_r;

  logic        clearing_r;
  logic [vurp_pkg::VRAM_AW-1:0] clr_cnt_r;

  logic [7:0]  ctrl_r, ctrl_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic [2:0]  status_r, status_nxt;
  logic [7:0]  last_wr_r, last_wr_nxt;
  logic        toggle_r, toggle_nxt;
  logic [13:0] vaddr_r, vaddr_nxt;
  logic [13:0] taddr_r, taddr_nxt;
  logic [2:0]  fine_x_r, fine_x_nxt;
  logic [2:0]  fine_y_r, fine_y_nxt;
  logic [7:0]  spr_ptr_r, spr_ptr_nxt;

  logic [7:0]  vram_rdata_r;
  logic [7:0]  spr_rdata_r;

  logic        out_valid_r;
  vurp_pkg::out_item_t out_data_r;
  logic        out_spr_sel_r;

  logic        acc;
  logic [7:0]  rd;
  logic        spr_sel;
  logic        spr_re, spr_we;
  logic        vram_re, vram_we;
  logic        pal_we;
  logic        step;
  logic [13:0] inc;

  logic        in_pattern, in_palette;
  logic [vurp_pkg::VRAM_AW-1:0] pat_idx, nt_idx, vram_ridx, vram_widx;
  logic [7:0]  vram_wdata;
  logic [7:0]  spr_widx;
  logic [7:0]  spr_wdata;
  logic [4:0]  pal_idx;

  assign acc       = in_valid && !in_stall;
  assign in_stall  = clearing_r || (out_valid_r && out_stall);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;

  assign in_pattern = !vaddr_r[13];
  assign in_palette = (vaddr_r[13:8] == 6'h3F);
  assign pat_idx    = {1'b0, vaddr_r[12:0]};
  assign nt_idx     = {2'b10, nt_page_r[vaddr_r[11:10]], vaddr_r[9:0]};
  assign vram_ridx  = in_pattern ? pat_idx : nt_idx;
  assign pal_idx    = vaddr_r[4:0];
  assign inc        = ctrl_r[2] ? 14'd32 : 14'd1;

  always_comb begin
    ctrl_nxt    = ctrl_r;
    mask_nxt    = mask_r;
    status_nxt  = status_r;
    last_wr_nxt = last_wr_r;
    toggle_nxt  = toggle_r;
    vaddr_nxt   = vaddr_r;
    taddr_nxt   = taddr_r;
    fine_x_nxt  = fine_x_r;
    fine_y_nxt  = fine_y_r;
    spr_ptr_nxt = spr_ptr_r;
    rd          = 8'h00;
    spr_sel     = 1'b0;
    spr_re      = 1'b0;
    spr_we      = 1'b0;
    vram_re     = 1'b0;
    vram_we     = 1'b0;
    pal_we      = 1'b0;
    step        = 1'b0;
    unique case (in_data.command)
      vurp_pkg::CMD_READ: begin
        unique case (in_data.reg_index)
          vurp_pkg::REG_STATUS: begin
            rd         = {status_r, last_wr_r[4:0]};
            status_nxt = {1'b0, status_r[1:0]};
            toggle_nxt = 1'b0;
          end
          vurp_pkg::REG_OAM_DATA: begin
            spr_re  = 1'b1;
            spr_sel = 1'b1;
          end
          vurp_pkg::REG_DATA: begin
            rd      = in_palette ? pal_r[pal_idx] : vram_rdata_r;
            vram_re = 1'b1;
            step    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      vurp_pkg::CMD_WRITE: begin
        last_wr_nxt = in_data.write_data;
        unique case (in_data.reg_index)
          vurp_pkg::REG_CONTROL: begin
            ctrl_nxt         = in_data.write_data;
            taddr_nxt[11:10] = in_data.write_data[1:0];
          end
          vurp_pkg::REG_MASK: begin
            mask_nxt = in_data.write_data;
          end
          vurp_pkg::REG_OAM_ADDR: begin
            spr_ptr_nxt = in_data.write_data;
          end
          vurp_pkg::REG_OAM_DATA: begin
            spr_we      = 1'b1;
            spr_ptr_nxt = spr_ptr_r + 8'd1;
          end
          vurp_pkg::REG_SCROLL: begin
            if (!toggle_r) begin
              fine_x_nxt     = in_data.write_data[2:0];
              taddr_nxt[4:0] = in_data.write_data[7:3];
              toggle_nxt     = 1'b1;
            end else begin
              fine_y_nxt     = in_data.write_data[2:0];
              taddr_nxt[9:5] = in_data.write_data[7:3];
              toggle_nxt     = 1'b0;
            end
          end
          vurp_pkg::REG_ADDR: begin
            if (!toggle_r) begin
              taddr_nxt[13:8] = in_data.write_data[5:0];
              toggle_nxt      = 1'b1;
            end else begin
              taddr_nxt[7:0] = in_data.write_data;
              vaddr_nxt      = {taddr_r[13:8], in_data.write_data};
              toggle_nxt     = 1'b0;
            end
          end
          vurp_pkg::REG_DATA: begin
            vram_we = (in_pattern && pat_wr_r) || (!in_pattern && !in_palette);
            pal_we  = in_palette;
            step    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      vurp_pkg::CMD_STATUS: begin
        status_nxt = {in_data.set_vblank, in_data.set_sprite_hit, in_data.set_overflow};
      end
      default: begin
      end
    endcase
    if (step) begin
      vaddr_nxt = vaddr_r + inc;
    end
  end

  always_comb begin
    if (clearing_r) begin
      vram_widx  = clr_cnt_r;
      vram_wdata = 8'h00;
      spr_widx   = clr_cnt_r[7:0];
      spr_wdata  = 8'h00;
    end else begin
      vram_widx  = vram_ridx;
      vram_wdata = in_data.write_data;
      spr_widx   = spr_ptr_r;
      spr_wdata  = in_data.write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r || (acc && vram_we)) begin
      vram_mem[vram_widx] <= vram_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vram_rdata_r <= 8'h00;
    end else if (acc && vram_re) begin
      vram_rdata_r <= vram_mem[vram_ridx];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r || (acc && spr_we)) begin
      spr_mem[spr_widx] <= spr_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && spr_re) begin
      spr_rdata_r <= spr_mem[spr_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vurp_pkg::PAL_DEPTH; i++) begin
        pal_r[i] <= 8'h00;
      end
    end else if (acc && pal_we) begin
      if (pal_idx[1:0] == 2'b00) begin
        pal_r[{1'b0, pal_idx[3:0]}] <= in_data.write_data;
        pal_r[{1'b1, pal_idx[3:0]}] <= in_data.write_data;
      end else begin
        pal_r[pal_idx] <= in_data.write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nt_page_r[0] <= 2'd0;
      nt_page_r[1] <= 2'd1;
      nt_page_r[2] <= 2'd2;
      nt_page_r[3] <= 2'd3;
      pat_wr_r     <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        vurp_pkg::CFG_PAGE_A: nt_page_r[0] <= cfg_data;
        vurp_pkg::CFG_PAGE_B: nt_page_r[1] <= cfg_data;
        vurp_pkg::CFG_PAGE_C: nt_page_r[2] <= cfg_data;
        vurp_pkg::CFG_PAGE_D: nt_page_r[3] <= cfg_data;
        vurp_pkg::CFG_PAT_WR: pat_wr_r     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      if (clr_cnt_r == vurp_pkg::VRAM_AW'(vurp_pkg::VRAM_DEPTH - 1)) begin
        clearing_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r    <= 8'h00;
      mask_r    <= 8'h00;
      status_r  <= 3'd0;
      last_wr_r <= 8'h00;
      toggle_r  <= 1'b0;
      vaddr_r   <= 14'd0;
      taddr_r   <= 14'd0;
      fine_x_r  <= 3'd0;
      fine_y_r  <= 3'd0;
      spr_ptr_r <= 8'h00;
    end else if (acc) begin
      ctrl_r    <= ctrl_nxt;
      mask_r    <= mask_nxt;
      status_r  <= status_nxt;
      last_wr_r <= last_wr_nxt;
      toggle_r  <= toggle_nxt;
      vaddr_r   <= vaddr_nxt;
      taddr_r   <= taddr_nxt;
      fine_x_r  <= fine_x_nxt;
      fine_y_r  <= fine_y_nxt;
      spr_ptr_r <= spr_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      out_spr_sel_r <= 1'b0;
    end else if (acc) begin
      out_valid_r   <= 1'b1;
      out_spr_sel_r <= spr_sel;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r.read_data       <= rd;
      out_data_r.current_address <= vaddr_nxt;
      out_data_r.pending_address <= taddr_nxt;
      out_data_r.fine_x          <= fine_x_nxt;
      out_data_r.fine_y          <= fine_y_nxt;
      out_data_r.control_value   <= ctrl_nxt;
      out_data_r.mask_value      <= mask_nxt;
      out_data_r.write_toggle    <= toggle_nxt;
    end
  end

  always_comb begin
    out_data = out_data_r;
    if (out_spr_sel_r) begin
      out_data.read_data = spr_rdata_r;
    end
  end

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> in_stall)
    else $error("Transaction accepted during the memory clearing pass.");

  a_addr_second_write_loads: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.command == vurp_pkg::CMD_WRITE &&
    in_data.reg_index == vurp_pkg::REG_ADDR && toggle_r
    |=> out_data.current_address == out_data.pending_address)
    else $error("Second address write did not load the video address.");

  a_status_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.command == vurp_pkg::CMD_READ &&
    in_data.reg_index == vurp_pkg::REG_STATUS
    |=> !toggle_r && !status_r[2])
    else $error("Status read did not clear the toggle and vertical blank flag.");

  a_palette_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    pal_r[0] == pal_r[16] && pal_r[4] == pal_r[20] &&
    pal_r[8] == pal_r[24] && pal_r[12] == pal_r[28])
    else $error("Mirrored palette entries diverged.");

endmodule
